// ===== hw/rtl/mrts_pkg.sv =====
// ----------------------------------------------------------------------------
// mrts_pkg
// Shared types and fixed field widths for the merged rank block.
// ----------------------------------------------------------------------------
package mrts_pkg;

  localparam int unsigned VALUE_IN_BITS = 32;  // width of the value input field
  localparam int unsigned POS_BITS      = 6;   // position field and smaller-count cells
  localparam int unsigned RANK_BITS     = 7;   // rank field

  // controller to datapath
  typedef struct packed {
    logic load;       // input transfer this cycle
    logic clear;      // batch done, counters back to zero
    logic rotate;     // move every stored cell one place towards the head
    logic emit;       // capture the head cell into the output register
    logic final_res;  // captured result is the last of the batch
  } mrts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;  // rank count for a loaded cell still in flight
    logic head_seq;   // sequence of the cell at the head
    logic out_stall;  // output register full and not being taken
  } mrts_status_t;

endpackage

// ===== hw/rtl/mrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrts_ctrl
// Load / drain / scan sequencer for the merged rank block.
// ----------------------------------------------------------------------------
module mrts_ctrl #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  batch_end_i,
  input  logic [CNT_W-1:0]      total_i,
  input  mrts_pkg::mrts_status_t status_i,
  output logic                  in_ready_o,
  output mrts_pkg::mrts_cmd_t   cmd_o
);
  import mrts_pkg::*;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic             pass_q, pass_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             match;

  assign match = (status_i.head_seq == pass_q);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    pass_d     = pass_q;
    rem_d      = rem_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (batch_end_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          if (total_i == '0) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            rem_d   = total_i;
            step_d  = '0;
            pass_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!(match && status_i.out_stall)) begin
          cmd_o.rotate = 1'b1;
          if (match) begin
            cmd_o.emit      = 1'b1;
            cmd_o.final_res = (rem_q == CNT_W'(1));
            rem_d           = rem_q - CNT_W'(1);
          end
          if (match && rem_q == CNT_W'(1)) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else if (step_q == IDX_W'(total_i - CNT_W'(1))) begin
            // every cell seen once in this pass, go on with sequence B
            step_d = '0;
            pass_d = 1'b1;
          end else begin
            step_d = step_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      step_q  <= '0;
      pass_q  <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ===== hw/rtl/mrts_datapath.sv =====
// ----------------------------------------------------------------------------
// mrts_datapath
// Cell row with per-cell comparators and counts, rank count tree, output register.
// ----------------------------------------------------------------------------
module mrts_datapath #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [mrts_pkg::VALUE_IN_BITS-1:0] value_i,
  input  logic                                   from_second_i,
  input  mrts_pkg::mrts_cmd_t                    cmd_i,
  input  logic                                   out_ready_i,
  output mrts_pkg::mrts_status_t                 status_o,
  output logic [CNT_W-1:0]                       total_o,
  output logic                                   out_valid_o,
  output logic                                   seq_select_o,
  output logic [mrts_pkg::POS_BITS-1:0]          position_o,
  output logic [mrts_pkg::RANK_BITS-1:0]         rank_o,
  output logic                                   final_result_o,
  output logic                                   overflowed_o
);
  import mrts_pkg::*;

  localparam int unsigned NGRP = (CAPACITY + 7) / 8;

  // cell row
  logic [VALUE_BITS-1:0] val_q [CAPACITY];
  logic [VALUE_BITS-1:0] val_d [CAPACITY];
  logic                  seq_q [CAPACITY];
  logic                  seq_d [CAPACITY];
  logic [POS_BITS-1:0]   pos_q [CAPACITY];
  logic [POS_BITS-1:0]   pos_d [CAPACITY];
  logic [POS_BITS-1:0]   cnt_q [CAPACITY];
  logic [POS_BITS-1:0]   cnt_d [CAPACITY];

  logic [CNT_W-1:0]      count_a_q, count_b_q;
  logic                  ovf_q;
  logic [CNT_W-1:0]      total;
  logic                  full;
  logic                  store;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      last_idx;
  logic [POS_BITS-1:0]   new_pos;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] key;
  logic [CAPACITY-1:0]   below;

  // rank count pipeline for the newly loaded cell
  logic                  p1_valid_q;
  logic [IDX_W-1:0]      p1_idx_q;
  logic [CAPACITY-1:0]   p1_vec_q;
  logic                  p2_valid_q;
  logic [IDX_W-1:0]      p2_idx_q;
  logic [3:0]            gsum_q [NGRP];
  logic [3:0]            gsum_d [NGRP];
  logic [NGRP*8-1:0]     pad;
  logic [CNT_W-1:0]      popsum;

  logic                  out_valid_q;
  logic                  out_seq_q;
  logic [POS_BITS-1:0]   out_pos_q;
  logic [RANK_BITS-1:0]  out_rank_q;
  logic                  out_final_q;
  logic                  out_ovf_q;

  // order key: low VALUE_BITS bits as two's complement (zero-extended if wider), sign bit flipped
  if (VALUE_BITS <= VALUE_IN_BITS) begin : g_key_narrow
    assign raw = value_i[VALUE_BITS-1:0];
  end else begin : g_key_wide
    assign raw = {{(VALUE_BITS - VALUE_IN_BITS){1'b0}}, value_i};
  end
  assign key = raw ^ {1'b1, {(VALUE_BITS - 1){1'b0}}};

  assign total    = CNT_W'(count_a_q + count_b_q);
  assign full     = (total >= CNT_W'(CAPACITY));
  assign store    = cmd_i.load && !full;
  assign wr_idx   = IDX_W'(total);
  assign last_idx = IDX_W'(total - CNT_W'(1));
  assign new_pos  = from_second_i ? POS_BITS'(count_b_q) : POS_BITS'(count_a_q);

  // a stored cell sorts below the new one if smaller, or equal and the new one is from B
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      below[i] = (CNT_W'(i) < total) &&
                 ((val_q[i] < key) || ((val_q[i] == key) && from_second_i));
    end
  end

  always_comb begin
    pad = '0;
    pad[CAPACITY-1:0] = p1_vec_q;
    for (int g = 0; g < NGRP; g++) begin
      gsum_d[g] = '0;
      for (int j = 0; j < 8; j++) begin
        gsum_d[g] = gsum_d[g] + 4'(pad[g*8+j]);
      end
    end
  end

  always_comb begin
    popsum = '0;
    for (int g = 0; g < NGRP; g++) begin
      popsum = popsum + CNT_W'(gsum_q[g]);
    end
  end

  always_comb begin
    logic [IDX_W-1:0]    src;
    logic [POS_BITS-1:0] add;
    src = '0;
    add = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      val_d[i] = val_q[i];
      seq_d[i] = seq_q[i];
      pos_d[i] = pos_q[i];
      cnt_d[i] = cnt_q[i];
      if (cmd_i.rotate) begin
        // the head cell wraps round to the last stored place
        src = ((IDX_W'(i) == last_idx) || (i == CAPACITY - 1)) ? '0 : IDX_W'(i + 1);
        val_d[i] = val_q[src];
        seq_d[i] = seq_q[src];
        pos_d[i] = pos_q[src];
        cnt_d[i] = cnt_q[src];
      end else if (store && (wr_idx == IDX_W'(i))) begin
        val_d[i] = key;
        seq_d[i] = from_second_i;
        pos_d[i] = new_pos;
        cnt_d[i] = '0;
      end else begin
        add = (p2_valid_q && (p2_idx_q == IDX_W'(i))) ? POS_BITS'(popsum) : '0;
        cnt_d[i] = cnt_q[i] + POS_BITS'(store && (CNT_W'(i) < total) && !below[i]) + add;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    seq_q    <= seq_d;
    pos_q    <= pos_d;
    cnt_q    <= cnt_d;
    p1_idx_q <= wr_idx;
    p1_vec_q <= below;
    p2_idx_q <= p1_idx_q;
    gsum_q   <= gsum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q  <= '0;
      count_b_q  <= '0;
      ovf_q      <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= store;
      p2_valid_q <= p1_valid_q;
      if (cmd_i.clear) begin
        count_a_q <= '0;
        count_b_q <= '0;
        ovf_q     <= 1'b0;
      end else if (store) begin
        if (from_second_i) begin
          count_b_q <= count_b_q + CNT_W'(1);
        end else begin
          count_a_q <= count_a_q + CNT_W'(1);
        end
      end else if (cmd_i.load) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_seq_q   <= seq_q[0];
      out_pos_q   <= pos_q[0];
      out_rank_q  <= RANK_BITS'(cnt_q[0]) + RANK_BITS'(1);
      out_final_q <= cmd_i.final_res;
      out_ovf_q   <= ovf_q;
    end
  end

  assign status_o.pipe_busy = p1_valid_q || p2_valid_q;
  assign status_o.head_seq  = seq_q[0];
  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign total_o            = total;
  assign out_valid_o        = out_valid_q;
  assign seq_select_o       = out_seq_q;
  assign position_o         = out_pos_q;
  assign rank_o             = out_rank_q;
  assign final_result_o     = out_final_q;
  assign overflowed_o       = out_ovf_q;

  a_no_emit_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("result captured while output register stalled");

  a_count_target_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_valid_q |-> (CNT_W'(p2_idx_q) < total))
    else $error("rank count aimed at a cell that is not stored");

  a_total_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= CNT_W'(CAPACITY))
    else $error("stored count beyond capacity");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (count_a_q == '0) && (count_b_q == '0) && !ovf_q)
    else $error("batch counters not cleared");

  a_no_rotate_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rotate |-> !(p1_valid_q || p2_valid_q || cmd_i.load))
    else $error("cells rotated while a load is in flight");

endmodule

// ===== hw/rtl/merged_rank_two_sequences.sv =====
// ----------------------------------------------------------------------------
// merged_rank_two_sequences
// Ranks the elements of two signed sequences in their merged sorted order.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one value per transfer, tagged A
// or B by from_second_i. Loads are taken one per cycle; each compares against
// every stored cell at once, and the new cell's own count settles through a
// two-stage count tree. Items beyond CAPACITY are dropped and flag overflow.
// The transfer with batch_end_i set is loaded too and starts the read-out:
// input ready drops, the count tree settles, then the cell row is rotated
// past its head twice, once for A and once for B. Each cycle moves one cell
// while the output is not stalled; a cell of the current sequence goes to
// the output register. Results come out A in load order, then B, with
// final_result_o on the last; an empty batch gives none.
// Output channel (out_valid_o / out_ready_i): while the receiver stalls the
// scan holds on the waiting cell; loading resumes once the last result is in
// the output register. Reset clears the counters and the valid flags; cell
// contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
module merged_rank_two_sequences #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic signed [mrts_pkg::VALUE_IN_BITS-1:0] value_i,
  input  logic                                      from_second_i,
  input  logic                                      batch_end_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic                                      seq_select_o,
  output logic [mrts_pkg::POS_BITS-1:0]             position_o,
  output logic [mrts_pkg::RANK_BITS-1:0]            rank_o,
  output logic                                      final_result_o,
  output logic                                      overflowed_o
);
  import mrts_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  mrts_cmd_t        cmd;
  mrts_status_t     status;
  logic [CNT_W-1:0] total;

  mrts_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .batch_end_i (batch_end_i),
    .total_i     (total),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  mrts_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .from_second_i  (from_second_i),
    .cmd_i          (cmd),
    .out_ready_i    (out_ready_i),
    .status_o       (status),
    .total_o        (total),
    .out_valid_o    (out_valid_o),
    .seq_select_o   (seq_select_o),
    .position_o     (position_o),
    .rank_o         (rank_o),
    .final_result_o (final_result_o),
    .overflowed_o   (overflowed_o)
  );

endmodule
